FILE: rtl/elb_pkg.sv
// package: types, constants and q16.16 helpers for the electrolyte balance step
`default_nettype none
package elb_pkg;

	localparam int unsigned MaxSubstepsDefault = 16;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 32;

	localparam logic signed [31:0] QOne = 32'sd65536;
	localparam logic signed [31:0] NaInit = 32'sd139591680;   // 2130.0
	localparam logic signed [31:0] KInit = 32'sd232652800;    // 3550.0
	localparam logic signed [31:0] WInit = 32'sd2621440;      // 40.0
	localparam logic signed [31:0] IInit = 32'sd1638400;      // 25.0
	localparam logic signed [31:0] K3000 = 32'sd196608000;    // 3000.0
	localparam logic signed [31:0] KDist = 32'sd611667;       // 9.3333

	typedef enum logic [CfgIdxW-1:0] {
		REG_NA_INTAKE  = 3'd0,
		REG_PLASMA     = 3'd1,
		REG_ALDO_GAIN  = 3'd2,
		REG_K_INTAKE   = 3'd3,
		REG_SHIFT_GAIN = 3'd4,
		REG_SUBSTEP    = 3'd5,
		REG_TOLERANCE  = 3'd6,
		REG_TIME_STEP  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] appetite_factor;
		logic signed [31:0] sodium_output;
		logic signed [31:0] potassium_output;
		logic signed [31:0] water_intake;
		logic signed [31:0] urine_volume;
		logic signed [31:0] aldo_multiplier;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] sodium_change;
		logic signed [31:0] sodium_total;
		logic signed [31:0] aldo_k_factor;
		logic signed [31:0] potassium_change;
		logic signed [31:0] potassium_total;
		logic signed [31:0] water_total;
		logic signed [31:0] k_extra;
		logic signed [31:0] k_intra;
		logic signed [31:0] extra_volume;
		logic signed [31:0] intra_volume;
		logic signed [31:0] sodium_conc;
		logic signed [31:0] potassium_conc;
	} out_beat_t;

	// divider request / response
	typedef struct packed {
		logic               start;
		logic signed [31:0] num;
		logic signed [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quo;
	} div_rsp_t;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
		if (x > 33'sd2147483647)
			return 32'sh7fffffff;
		else if (x < -33'sd2147483648)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

	function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat33(33'(a) + 33'(b));
	endfunction

	function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat33(33'(a) - 33'(b));
	endfunction

	// product shifted down with floor, saturated
	function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
		logic signed [47:0] s;
		s = p[63:16];
		if (s > 48'sd2147483647)
			return 32'sh7fffffff;
		else if (s < -48'sd2147483648)
			return 32'sh80000000;
		else
			return s[31:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/electrolyte_balance_step.sv
// top level: electrolyte balance step with shared multiplier and divider
// sequence: store integration, then per sub-step four divisions plus shift, update
// and test, then the last division and the result register
// a new item is taken only in idle; in_stall is high while an item is at work
// reset: config registers to their defaults, stores to the model start values
`default_nettype none
module electrolyte_balance_step
	import elb_pkg::*;
#(
	parameter int unsigned MAX_SUBSTEPS = MaxSubstepsDefault
)(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  in_beat_t                 in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output out_beat_t                out_data,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_value
);
	localparam int unsigned CntW = $clog2(MAX_SUBSTEPS + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_NA1, S_NA2, S_NA3, S_ALDO, S_ALDO2, S_K, S_W, S_W2,
		S_KE1, S_KE2, S_VEC, S_CNA, S_CKI, S_SHIFT, S_INTRA, S_CHECK,
		S_CKE, S_OUT
	} state_t;

	state_t state_q;
	// config
	logic signed [31:0] na_intake_q, plasma_q, aldo_gain_q, k_intake_q, shift_gain_q;
	logic [30:0] substep_q, tol_q, tstep_q;
	// stores
	logic signed [31:0] na_q, k_q, w_q, ic_q;
	// item and temporaries
	in_beat_t in_q;
	logic signed [31:0] na_chg_q, aldo_k_q, k_chg_q, ke_q, ki_q, vec_q, cna_q;
	logic signed [31:0] cki_q, shift_q, tmp_q;
	logic [31:0] elapsed_q;   // substep sum, capped compare below
	logic [CntW-1:0] count_q;
	logic wait_q;

	// shared multiplier: one 32x32 product per cycle, operands chosen by state
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic signed [31:0] mq;
	assign prod = ma * mb;
	assign mq = qscale(prod);

	div_req_t dreq;
	div_rsp_t drsp;
	elb_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_NA1: begin
				ma = na_intake_q;
				mb = in_q.appetite_factor;
			end
			S_NA3: begin
				ma = na_chg_q;
				mb = 32'(tstep_q);
			end
			S_ALDO: begin
				ma = qsub(in_q.aldo_multiplier, QOne);
				mb = aldo_gain_q;
			end
			S_K: begin
				ma = k_chg_q;
				mb = 32'(tstep_q);
			end
			S_W2: begin
				ma = tmp_q;
				mb = 32'(tstep_q);
			end
			S_SHIFT: begin
				ma = qsub(cki_q, cna_q);
				mb = shift_gain_q;
			end
			S_INTRA: begin
				ma = shift_q;
				mb = 32'(substep_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// divider launches
	always_comb begin
		dreq = '0;
		if (!wait_q) begin
			case (state_q)
				S_KE1: begin
					dreq.start = 1'b1;
					dreq.num = qsub(k_q, K3000);
					dreq.den = aldo_k_q;
				end
				S_KE2: begin
					dreq.start = 1'b1;
					dreq.num = tmp_q;
					dreq.den = KDist;
				end
				S_CNA: begin
					dreq.start = 1'b1;
					dreq.num = na_q;
					dreq.den = vec_q;
				end
				S_CKI: begin
					dreq.start = 1'b1;
					dreq.num = ki_q;
					dreq.den = ic_q;
				end
				S_CKE: begin
					dreq.start = 1'b1;
					dreq.num = ke_q;
					dreq.den = vec_q;
				end
				default: dreq = '0;
			endcase
		end
	end

	logic signed [31:0] mag_shift;
	logic [32:0] elapsed_nx;
	assign mag_shift = shift_q[31] ? 32'(-33'(shift_q)) : shift_q;
	assign elapsed_nx = {1'b0, elapsed_q} + {2'b0, substep_q};

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			wait_q <= 1'b0;
			na_intake_q <= '0;
			plasma_q <= '0;
			aldo_gain_q <= '0;
			k_intake_q <= '0;
			shift_gain_q <= '0;
			substep_q <= 31'd65536;
			tol_q <= '0;
			tstep_q <= 31'd65536;
			na_q <= NaInit;
			k_q <= KInit;
			w_q <= WInit;
			ic_q <= IInit;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_NA_INTAKE:  na_intake_q <= cfg_value;
					REG_PLASMA:     plasma_q <= cfg_value;
					REG_ALDO_GAIN:  aldo_gain_q <= cfg_value;
					REG_K_INTAKE:   k_intake_q <= cfg_value;
					REG_SHIFT_GAIN: shift_gain_q <= cfg_value;
					REG_SUBSTEP:    substep_q <= cfg_value[30:0];
					REG_TOLERANCE:  tol_q <= cfg_value[30:0];
					REG_TIME_STEP:  tstep_q <= cfg_value[30:0];
					default: ;
				endcase
			end
			// result beat goes up once the output register is free
			if (state_q == S_OUT && (!out_valid || !out_stall))
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_q <= in_data;
						state_q <= S_NA1;
					end
				end
				S_NA1: begin
					tmp_q <= qsub(mq, in_q.sodium_output);
					state_q <= S_NA2;
				end
				S_NA2: begin
					// 142 * plasma added before saturation, exact in 64 bits
					na_chg_q <= qscale({{16{tmp_q[31]}}, tmp_q, 16'd0}
						+ ({{16{plasma_q[31]}}, plasma_q, 16'd0} * 64'd142));
					state_q <= S_NA3;
				end
				S_NA3: begin
					na_q <= qadd(na_q, mq);
					state_q <= S_ALDO;
				end
				S_ALDO: begin
					aldo_k_q <= qadd(mq, QOne);
					k_chg_q <= qsub(k_intake_q, in_q.potassium_output);
					state_q <= S_K;
				end
				S_K: begin
					k_q <= qadd(k_q, mq);
					tmp_q <= qsub(in_q.water_intake, in_q.urine_volume);
					state_q <= S_W2;
				end
				S_W2: begin
					w_q <= qadd(w_q, mq);
					elapsed_q <= '0;
					count_q <= '0;
					state_q <= S_KE1;
				end
				S_KE1: begin
					if (wait_q && drsp.done) begin
						wait_q <= 1'b0;
						tmp_q <= drsp.quo;
						state_q <= S_KE2;
					end else
						wait_q <= 1'b1;
				end
				S_KE2: begin
					if (wait_q && drsp.done) begin
						wait_q <= 1'b0;
						ke_q <= drsp.quo;
						ki_q <= qsub(k_q, drsp.quo);
						vec_q <= qsub(w_q, ic_q);
						state_q <= S_CNA;
					end else
						wait_q <= 1'b1;
				end
				S_CNA: begin
					if (wait_q && drsp.done) begin
						wait_q <= 1'b0;
						cna_q <= drsp.quo;
						state_q <= S_CKI;
					end else
						wait_q <= 1'b1;
				end
				S_CKI: begin
					if (wait_q && drsp.done) begin
						wait_q <= 1'b0;
						cki_q <= drsp.quo;
						state_q <= S_SHIFT;
					end else
						wait_q <= 1'b1;
				end
				S_SHIFT: begin
					shift_q <= mq;
					state_q <= S_INTRA;
				end
				S_INTRA: begin
					ic_q <= qadd(ic_q, mq);
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					// stop on small shift, elapsed time or sub-step cap
					if ({1'b0, mag_shift} < {2'b0, tol_q})
						state_q <= S_CKE;
					else if (elapsed_nx >= {2'b0, tstep_q}
							|| 32'(count_q) + 32'd1 >= 32'(MAX_SUBSTEPS))
						state_q <= S_CKE;
					else begin
						elapsed_q <= elapsed_nx[31:0];
						count_q <= count_q + CntW'(1);
						state_q <= S_KE1;
					end
				end
				S_CKE: begin
					if (wait_q && drsp.done) begin
						wait_q <= 1'b0;
						tmp_q <= drsp.quo;
						state_q <= S_OUT;
					end else
						wait_q <= 1'b1;
				end
				S_OUT: begin
					// a stalled result beat is left alone until taken
					if (!out_valid || !out_stall) begin
						out_data.sodium_change <= na_chg_q;
						out_data.sodium_total <= na_q;
						out_data.aldo_k_factor <= aldo_k_q;
						out_data.potassium_change <= k_chg_q;
						out_data.potassium_total <= k_q;
						out_data.water_total <= w_q;
						out_data.k_extra <= ke_q;
						out_data.k_intra <= ki_q;
						out_data.extra_volume <= vec_q;
						out_data.intra_volume <= ic_q;
						out_data.sodium_conc <= cna_q;
						out_data.potassium_conc <= tmp_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/elb_div.sv
// iterative q16.16 divider: (a<<16)/b, truncating, saturating
`default_nettype none
module elb_div
	import elb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  div_req_t      req,
	output div_rsp_t      rsp
);
	localparam int unsigned NumW = 48;

	logic [NumW-1:0] rem_q;
	logic [NumW-1:0] quo_q;
	logic [31:0]     den_q;
	logic [5:0]      cnt_q;
	logic            busy_q;
	logic            neg_q;
	logic            zero_q;
	logic            nsign_q;
	logic            nzero_q;
	logic            done_q;
	logic signed [31:0] res_q;

	logic [NumW:0]   trial;
	logic [NumW-1:0] rem_sh;
	logic [NumW:0]   mag;

	assign rem_sh = {rem_q[NumW-2:0], quo_q[NumW-1]};
	assign trial = {1'b0, rem_sh} - {17'd0, den_q};
	assign mag = {1'b0, quo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			// done pulses the cycle after the last quotient bit
			done_q <= busy_q && (cnt_q == 6'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(NumW);
				rem_q <= '0;
				quo_q <= {(req.num[31] ? 32'(-33'(req.num)) : req.num), 16'd0};
				den_q <= req.den[31] ? 32'(-33'(req.den)) : req.den;
				neg_q <= req.num[31] ^ req.den[31];
				zero_q <= (req.den == '0);
				nsign_q <= req.num[31];
				nzero_q <= (req.num == '0);
			end else if (busy_q) begin
				if (!trial[NumW]) begin
					rem_q <= trial[NumW-1:0];
					quo_q <= {quo_q[NumW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[NumW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1)
					busy_q <= 1'b0;
			end
		end
	end

	// final sign and saturation, from quotient after last shift, and zero-divisor result
	logic [NumW-1:0] qfin;
	logic signed [31:0] qres;
	always_comb begin
		qfin = quo_q;
		if (zero_q)
			qres = nzero_q ? 32'sd0 : (nsign_q ? 32'sh80000000 : 32'sh7fffffff);
		else if (!neg_q)
			qres = (qfin > 48'd2147483647) ? 32'sh7fffffff : qfin[31:0];
		else
			qres = (qfin > 48'd2147483648) ? 32'sh80000000 : 32'(-49'(mag));
	end

	assign res_q = qres;
	assign rsp.done = done_q;
	assign rsp.quo = res_q;
endmodule
`default_nettype wire

FILE: rtl/elb_checker.sv
// port-level checker for the electrolyte balance step, bound to the top level
`default_nettype none
module elb_checker
	import elb_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_stall,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input out_beat_t      out_data
);
	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed under stall");

	// a beat is taken only when idle, and then the block goes busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after accepting a beat");

	// no result right after an accept
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result appeared without work");

	// a new result shows only as the block returns to idle
	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result raised while still busy");
endmodule

bind electrolyte_balance_step elb_checker u_elb_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

FILE: tb/tb.sv
// testbench for the electrolyte balance step: random and directed steps against a predictor
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import elb_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 200;
	localparam int unsigned WATCHDOG_LIMIT = 60000;
	localparam int unsigned N_SUBSTEPS = MaxSubstepsDefault;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_data;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_value = '0;

	// predictor copy of the configuration and the body stores
	logic signed [31:0] na_intake, plasma, aldo_gain, k_intake, shift_gain;
	logic signed [31:0] substep_len, tolerance, step_len;
	logic signed [31:0] na_store, k_store, w_store, ic_store;

	in_beat_t step_queue[$];
	out_beat_t balance_queue[$];
	int unsigned mismatches = 0;
	int unsigned steps_checked = 0;
	int unsigned steps_sent = 0;
	int unsigned idle_cycles = 0;
	int unsigned in_gap = 0;
	int unsigned out_gap = 0;
	bit stim_done = 1'b0;

	electrolyte_balance_step i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_value(cfg_value)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic signed [31:0] clamp64(input longint x);
		if (x > 64'sd2147483647)
			return 32'sh7fffffff;
		if (x < -64'sd2147483648)
			return 32'sh80000000;
		return x[31:0];
	endfunction

	function automatic logic signed [31:0] fx_add(input longint a, input longint b);
		return clamp64(a + b);
	endfunction

	function automatic logic signed [31:0] fx_sub(input longint a, input longint b);
		return clamp64(a - b);
	endfunction

	// exact product, floor shift by 16
	function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return clamp64(p >>> 16);
	endfunction

	// (a << 16) / b truncated, zero divisor saturates by the dividend's sign
	function automatic logic signed [31:0] fx_div(input longint a, input longint b);
		if (b == 0) begin
			if (a > 0)
				return 32'sh7fffffff;
			if (a < 0)
				return 32'sh80000000;
			return 32'sd0;
		end
		return clamp64((a * 65536) / b);
	endfunction

	function automatic void reset_model();
		na_intake = 0; plasma = 0; aldo_gain = 0; k_intake = 0; shift_gain = 0;
		substep_len = QOne; tolerance = 0; step_len = QOne;
		na_store = NaInit; k_store = KInit; w_store = WInit; ic_store = IInit;
	endfunction

	// one model time step: integrate the stores, then relax intracellular volume
	function automatic out_beat_t predict_balance(input in_beat_t s);
		out_beat_t r;
		logic signed [31:0] na_chg, aldo_k, k_chg, ke, ki, vec, cna, cki, shift;
		longint elapsed, mag;
		int count;
		elapsed = 0;
		count = 0;
		na_chg = fx_add(fx_sub(fx_mul(na_intake, s.appetite_factor), s.sodium_output),
			longint'(plasma) * 142);
		na_store = fx_add(na_store, fx_mul(na_chg, step_len));
		aldo_k = fx_add(fx_mul(fx_sub(s.aldo_multiplier, QOne), aldo_gain), QOne);
		k_chg = fx_sub(k_intake, s.potassium_output);
		k_store = fx_add(k_store, fx_mul(k_chg, step_len));
		w_store = fx_add(w_store, fx_mul(fx_sub(s.water_intake, s.urine_volume), step_len));
		forever begin
			ke = fx_div(fx_div(fx_sub(k_store, K3000), aldo_k), KDist);
			ki = fx_sub(k_store, ke);
			vec = fx_sub(w_store, ic_store);
			cna = fx_div(na_store, vec);
			cki = fx_div(ki, ic_store);
			shift = fx_mul(fx_sub(cki, cna), shift_gain);
			ic_store = fx_add(ic_store, fx_mul(shift, substep_len));
			mag = (shift < 0) ? -longint'(shift) : longint'(shift);
			if (mag < longint'(tolerance))
				break;
			elapsed += substep_len;
			count++;
			if (elapsed >= longint'(step_len) || count >= N_SUBSTEPS)
				break;
		end
		r.sodium_change = na_chg;
		r.sodium_total = na_store;
		r.aldo_k_factor = aldo_k;
		r.potassium_change = k_chg;
		r.potassium_total = k_store;
		r.water_total = w_store;
		r.k_extra = ke;
		r.k_intra = ki;
		r.extra_volume = vec;
		r.intra_volume = ic_store;
		r.sodium_conc = cna;
		r.potassium_conc = fx_div(ke, vec);
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 4);
		return $urandom_range(5, 60);
	endfunction

	// mostly physiological magnitudes, sometimes any 32-bit pattern
	function automatic logic signed [31:0] rand_rate(input int unsigned span);
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return $signed($urandom_range(0, 2 * span)) - $signed(span);
	endfunction

	function automatic in_beat_t rand_step();
		in_beat_t s;
		s.appetite_factor = rand_rate(32'h0003_0000);
		s.sodium_output = rand_rate(32'h00c8_0000);
		s.potassium_output = rand_rate(32'h0064_0000);
		s.water_intake = rand_rate(32'h0005_0000);
		s.urine_volume = rand_rate(32'h0005_0000);
		s.aldo_multiplier = rand_rate(32'h0004_0000);
		return s;
	endfunction

	// register write at the next edge, mirrored into the predictor
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_value <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_NA_INTAKE: na_intake = val;
			REG_PLASMA: plasma = val;
			REG_ALDO_GAIN: aldo_gain = val;
			REG_K_INTAKE: k_intake = val;
			REG_SHIFT_GAIN: shift_gain = val;
			REG_SUBSTEP: substep_len = {1'b0, val[30:0]};
			REG_TOLERANCE: tolerance = {1'b0, val[30:0]};
			REG_TIME_STEP: step_len = {1'b0, val[30:0]};
			default: ;
		endcase
	endtask

	// block is idle once every beat sent came back, then settle
	task automatic drain();
		wait (step_queue.size() == 0 && balance_queue.size() == 0 && !in_valid);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_step(input in_beat_t s);
		step_queue.push_back(s);
	endtask

	// driver: the front of the queue is the beat on the bus until it is accepted
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			balance_queue.push_back(predict_balance(in_data));
			steps_sent++;
			void'(step_queue.pop_front());
			in_gap = pick_gap();
		end
		if (!in_valid || !in_stall) begin
			if (step_queue.size() > 0 && in_gap == 0) begin
				in_valid <= 1'b1;
				in_data <= step_queue[0];
			end else begin
				in_valid <= 1'b0;
				if (in_gap > 0)
					in_gap--;
			end
		end
	end

	// monitor: compare each accepted result beat with the oldest prediction
	always @(posedge clk) begin
		out_beat_t want;
		if (out_valid && !out_stall) begin
			if (balance_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %p", out_data);
			end else begin
				want = balance_queue.pop_front();
				steps_checked++;
				if (want !== out_data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at step %0d\n  expected %p\n  actual   %p",
							steps_checked, want, out_data);
				end
			end
		end
		if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 3) == 0) begin
			out_gap = pick_gap();
			out_stall <= (out_gap > 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on cycles without any accepted beat or register write
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else if (!stim_done)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		in_beat_t s;
		int phase;
		reset_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults first, then extremes of each field
		s = '0;
		queue_step(s);
		s.aldo_multiplier = QOne;
		queue_step(s);
		queue_step('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh80000000});
		queue_step('{32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
		queue_step('1);
		drain();
		// aldo factor of zero: zero divisor on the potassium split
		write_reg(REG_ALDO_GAIN, 32'h0001_0000);
		write_reg(REG_SHIFT_GAIN, 32'h0000_0100);
		write_reg(REG_NA_INTAKE, 32'h0002_0000);
		write_reg(REG_PLASMA, 32'hffff_8000);
		write_reg(REG_K_INTAKE, 32'h0010_0000);
		s = '0;
		queue_step(s);
		s.water_intake = 32'h0100_0000;
		s.aldo_multiplier = 32'h0002_0000;
		queue_step(s);
		drain();
		// zero time step, zero substep, big tolerance, extreme registers
		write_reg(REG_TIME_STEP, 32'h0000_0000);
		queue_step(rand_step());
		drain();
		write_reg(REG_TIME_STEP, 32'h7fff_ffff);
		write_reg(REG_SUBSTEP, 32'h0000_0000);
		queue_step(rand_step());
		drain();
		write_reg(REG_SUBSTEP, 32'hffff_ffff);
		write_reg(REG_TOLERANCE, 32'hffff_ffff);
		write_reg(REG_SHIFT_GAIN, 32'h7fff_ffff);
		write_reg(REG_NA_INTAKE, 32'h8000_0000);
		write_reg(REG_PLASMA, 32'h7fff_ffff);
		write_reg(REG_ALDO_GAIN, 32'h8000_0000);
		write_reg(REG_K_INTAKE, 32'h8000_0000);
		queue_step(rand_step());
		queue_step(rand_step());
		drain();

		// random phases with fresh settings; stores carry over from the previous phase
		for (phase = 0; phase < 12; phase++) begin
			write_reg(REG_NA_INTAKE, rand_rate(32'h0064_0000));
			write_reg(REG_PLASMA, rand_rate(32'h0001_0000));
			write_reg(REG_ALDO_GAIN, rand_rate(32'h0002_0000));
			write_reg(REG_K_INTAKE, rand_rate(32'h0064_0000));
			write_reg(REG_SHIFT_GAIN, rand_rate(32'h0000_4000));
			write_reg(REG_SUBSTEP, (phase % 4 == 0) ? $urandom : $urandom_range(1, 32'h0001_0000));
			write_reg(REG_TOLERANCE, (phase % 3 == 0) ? 32'h0 : $urandom_range(0, 32'h0000_8000));
			write_reg(REG_TIME_STEP, (phase % 5 == 0) ? $urandom : $urandom_range(1, 32'h0004_0000));
			write_reg(cfg_reg_t'($urandom_range(0, 7)), $urandom);
			repeat (125)
				queue_step(rand_step());
			drain();
		end
		stim_done = 1'b1;

		$display("checked %0d time steps over 12 random register settings", steps_checked);
		$display("plus directed extremes, zero divisors and sub-step limits");
		if (mismatches == 0 && balance_queue.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
